FILE: hw/rtl/lrpb_pkg.sv
// Shared types and constants for the line rasterizer panel byte stream.
package lrpb_pkg;

  // Coordinate and walk widths
  localparam int COORD_BITS = 9;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int LEFT_BITS  = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_OP = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_OP    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MEMWR_OP  = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] COLUMN_OP_RST = 8'd42;
  localparam logic [CFG_DATA_BITS-1:0] ROW_OP_RST    = 8'd43;
  localparam logic [CFG_DATA_BITS-1:0] MEMWR_OP_RST  = 8'd44;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd3
  } dir_e;

  // Byte slots of one point's sequence
  typedef enum logic [3:0] {
    SLOT_COL_OP,
    SLOT_X_HI0,
    SLOT_X_LO0,
    SLOT_X_HI1,
    SLOT_X_LO1,
    SLOT_ROW_OP,
    SLOT_Y_HI0,
    SLOT_Y_LO0,
    SLOT_Y_HI1,
    SLOT_Y_LO1,
    SLOT_MEM_OP,
    SLOT_C_HI,
    SLOT_C_LO
  } slot_e;

  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] pixel_color;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
    logic       point_end;
    logic       line_end;
  } out_t;

  // One point handed from the walker to the serializer
  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pt_t;

endpackage

FILE: hw/rtl/line_raster_to_panel_bytes_top.sv
// Top level of the line rasterizer that emits panel write bytes.
//
//  Channel   Handshake          Payload                      Direction
//  command   push / full        in_item_i (in_t)             in
//  bytes     pop / empty        out_item_o (out_t)           out
//  config    cfg_we_i           cfg_idx_i, cfg_data_i        in
//
// The walker takes one command per cycle while the point queue has room.
// Each step that yields a point becomes 13 bytes at the output, one byte per
// cycle while pop is asserted, set by the single serializer and its output register.
// Reset clears the line, the queue and the output; opcodes return to 42/43/44.
// A stall on pop holds the output byte; the queue then fills and raises full.
module line_raster_to_panel_bytes_top import lrpb_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  in_t                      in_item_i,
  output logic                     empty,
  input  logic                     pop,
  output out_t                     out_item_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  logic acc;
  logic pt_push, q_pop, q_empty;
  pt_t  pt_in, pt_out;

  assign acc = push && !full;

  lrpb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .item_i    (in_item_i),
    .pt_push_o (pt_push),
    .pt_o      (pt_in)
  );

  lrpb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pt_push),
    .data_i  (pt_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (pt_out),
    .empty_o (q_empty)
  );

  lrpb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_empty_i  (q_empty),
    .q_data_i   (pt_out),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_o      (out_item_o)
  );

  // Point end only on the color low data byte, which closes the frame
  a_point_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.point_end |-> out_item_o.frame_end && out_item_o.is_data)
    else $error("point end on a byte that is not the color low byte");

  // Line end marks a point end
  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.line_end |-> out_item_o.point_end)
    else $error("line end without point end");

  // Every opcode byte closes its frame
  a_cmd_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_item_o.is_data |-> out_item_o.frame_end && !out_item_o.point_end)
    else $error("opcode byte without frame end");

endmodule

FILE: hw/rtl/lrpb_front.sv
// Line walker: takes start and step commands and emits one point per step.
module lrpb_front import lrpb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic acc_i,
  input  in_t  item_i,
  output logic pt_push_o,
  output pt_t  pt_o
);

  logic                  active_q, active_d;
  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  dir_e                  col_dir_q, col_dir_d, row_dir_q, row_dir_d;
  logic [COORD_BITS-1:0] span_col_q, span_col_d, span_row_q, span_row_d;
  logic [COORD_BITS-1:0] major_q, major_d;
  logic [ERR_BITS-1:0]   col_err_q, col_err_d, row_err_q, row_err_d;
  logic [LEFT_BITS-1:0]  left_q, left_d;
  logic [COLOR_BITS-1:0] color_q, color_d;

  logic                  step;
  logic                  last;
  logic [ERR_BITS-1:0]   col_sum, row_sum;
  logic [COORD_BITS-1:0] sx_span, sy_span, s_major;
  dir_e                  sx_dir, sy_dir;

  // Set up both axes from their endpoints
  always_comb begin
    if (item_i.end_x > item_i.start_x) begin
      sx_dir  = DIR_PLUS;
      sx_span = item_i.end_x - item_i.start_x;
    end else if (item_i.end_x == item_i.start_x) begin
      sx_dir  = DIR_NONE;
      sx_span = '0;
    end else begin
      sx_dir  = DIR_MINUS;
      sx_span = item_i.start_x - item_i.end_x;
    end
    if (item_i.end_y > item_i.start_y) begin
      sy_dir  = DIR_PLUS;
      sy_span = item_i.end_y - item_i.start_y;
    end else if (item_i.end_y == item_i.start_y) begin
      sy_dir  = DIR_NONE;
      sy_span = '0;
    end else begin
      sy_dir  = DIR_MINUS;
      sy_span = item_i.start_y - item_i.end_y;
    end
    s_major = (sx_span > sy_span) ? sx_span : sy_span;
  end

  assign step    = acc_i && (item_i.command == CMD_STEP) && active_q;
  assign last    = (left_q <= LEFT_BITS'(1));
  assign col_sum = col_err_q + ERR_BITS'(span_col_q);
  assign row_sum = row_err_q + ERR_BITS'(span_row_q);

  // Hand the current point to the queue
  assign pt_push_o = step;
  assign pt_o      = '{col: col_q, row: row_q, color: color_q, last: last};

  // Load a new line or advance the walk
  always_comb begin
    active_d   = active_q;
    col_d      = col_q;
    row_d      = row_q;
    col_dir_d  = col_dir_q;
    row_dir_d  = row_dir_q;
    span_col_d = span_col_q;
    span_row_d = span_row_q;
    major_d    = major_q;
    col_err_d  = col_err_q;
    row_err_d  = row_err_q;
    left_d     = left_q;
    color_d    = color_q;
    if (acc_i && item_i.command == CMD_START) begin
      active_d   = 1'b1;
      col_d      = item_i.start_x;
      row_d      = item_i.start_y;
      col_dir_d  = sx_dir;
      row_dir_d  = sy_dir;
      span_col_d = sx_span;
      span_row_d = sy_span;
      major_d    = s_major;
      col_err_d  = '0;
      row_err_d  = '0;
      left_d     = LEFT_BITS'(s_major) + LEFT_BITS'(2);
      color_d    = item_i.pixel_color;
    end else if (step) begin
      col_err_d = col_sum;
      row_err_d = row_sum;
      if (col_sum > ERR_BITS'(major_q)) begin
        col_err_d = col_sum - ERR_BITS'(major_q);
        if (col_dir_q == DIR_PLUS) begin
          col_d = col_q + 1'b1;
        end else if (col_dir_q == DIR_MINUS) begin
          col_d = col_q - 1'b1;
        end
      end
      if (row_sum > ERR_BITS'(major_q)) begin
        row_err_d = row_sum - ERR_BITS'(major_q);
        if (row_dir_q == DIR_PLUS) begin
          row_d = row_q + 1'b1;
        end else if (row_dir_q == DIR_MINUS) begin
          row_d = row_q - 1'b1;
        end
      end
      if (last) begin
        active_d = 1'b0;
        left_d   = '0;
      end else begin
        left_d = left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      col_dir_q  <= DIR_NONE;
      row_dir_q  <= DIR_NONE;
      span_col_q <= '0;
      span_row_q <= '0;
      major_q    <= '0;
      col_err_q  <= '0;
      row_err_q  <= '0;
      left_q     <= '0;
      color_q    <= '0;
    end else begin
      active_q   <= active_d;
      col_q      <= col_d;
      row_q      <= row_d;
      col_dir_q  <= col_dir_d;
      row_dir_q  <= row_dir_d;
      span_col_q <= span_col_d;
      span_row_q <= span_row_d;
      major_q    <= major_d;
      col_err_q  <= col_err_d;
      row_err_q  <= row_err_d;
      left_q     <= left_d;
      color_q    <= color_d;
    end
  end

endmodule

FILE: hw/rtl/lrpb_queue.sv
// Small point queue between the walker and the byte serializer.
module lrpb_queue import lrpb_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pt_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output pt_t  data_o,
  output logic empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pt_t           mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/lrpb_back.sv
// Byte serializer: turns each queued point into thirteen panel bytes.
module lrpb_back import lrpb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     q_empty_i,
  input  pt_t                      q_data_i,
  output logic                     q_pop_o,
  output logic                     empty_o,
  input  logic                     pop_i,
  output out_t                     out_o
);

  logic [CFG_DATA_BITS-1:0] col_op_q, row_op_q, mem_op_q;
  pt_t   cur_q, cur_d;
  logic  cur_vld_q, cur_vld_d;
  slot_e slot_q, slot_d;
  out_t  out_q, out_d;
  logic  out_vld_q, out_vld_d;
  logic  emit, last_slot, take;
  logic [15:0] col_ext, row_ext;

  // Hold the opcode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_op_q <= COLUMN_OP_RST;
      row_op_q <= ROW_OP_RST;
      mem_op_q <= MEMWR_OP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLUMN_OP: col_op_q <= cfg_data_i;
        CFG_ROW_OP:    row_op_q <= cfg_data_i;
        CFG_MEMWR_OP:  mem_op_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign emit      = cur_vld_q && (!out_vld_q || pop_i);
  assign last_slot = (slot_q == SLOT_C_LO);
  assign take      = !q_empty_i && (!cur_vld_q || (emit && last_slot));
  assign q_pop_o   = take;

  // Next slot and point register
  always_comb begin
    slot_d    = slot_q;
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    if (emit) begin
      if (last_slot) begin
        slot_d    = SLOT_COL_OP;
        cur_vld_d = 1'b0;
      end else begin
        slot_d = slot_e'(4'(slot_q) + 4'd1);
      end
    end
    if (take) begin
      cur_d     = q_data_i;
      cur_vld_d = 1'b1;
      slot_d    = SLOT_COL_OP;
    end
  end

  assign col_ext = 16'(cur_q.col);
  assign row_ext = 16'(cur_q.row);

  // Decode the byte of the current slot
  always_comb begin
    out_d = '{out_byte: 8'h00, is_data: 1'b1, frame_end: 1'b0,
              point_end: 1'b0, line_end: 1'b0};
    unique case (slot_q)
      SLOT_COL_OP: begin
        out_d.out_byte  = col_op_q;
        out_d.is_data   = 1'b0;
        out_d.frame_end = 1'b1;
      end
      SLOT_X_HI0, SLOT_X_HI1: out_d.out_byte = col_ext[15:8];
      SLOT_X_LO0: out_d.out_byte = col_ext[7:0];
      SLOT_X_LO1: begin
        out_d.out_byte  = col_ext[7:0];
        out_d.frame_end = 1'b1;
      end
      SLOT_ROW_OP: begin
        out_d.out_byte  = row_op_q;
        out_d.is_data   = 1'b0;
        out_d.frame_end = 1'b1;
      end
      SLOT_Y_HI0, SLOT_Y_HI1: out_d.out_byte = row_ext[15:8];
      SLOT_Y_LO0: out_d.out_byte = row_ext[7:0];
      SLOT_Y_LO1: begin
        out_d.out_byte  = row_ext[7:0];
        out_d.frame_end = 1'b1;
      end
      SLOT_MEM_OP: begin
        out_d.out_byte  = mem_op_q;
        out_d.is_data   = 1'b0;
        out_d.frame_end = 1'b1;
      end
      SLOT_C_HI: out_d.out_byte = cur_q.color[15:8];
      SLOT_C_LO: begin
        out_d.out_byte  = cur_q.color[7:0];
        out_d.frame_end = 1'b1;
        out_d.point_end = 1'b1;
        out_d.line_end  = cur_q.last;
      end
      default: ;
    endcase
  end

  // Output register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      slot_q    <= SLOT_COL_OP;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      slot_q    <= slot_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign empty_o = !out_vld_q;
  assign out_o   = out_q;

endmodule
